[design/carsr_pkg.sv]
package carsr_pkg;

   localparam int COORD_BITS  = 12;
   localparam logic [11:0] COORD_MASK =
      (COORD_BITS >= 12) ? 12'hFFF : 12'((1 << COORD_BITS) - 1);

   localparam int ROOT_BITS   = 12;
   localparam int NUM_BITS    = 2 * ROOT_BITS;
   localparam int REM_BITS    = NUM_BITS + 1;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [31:0] ARGB_ALPHA = 32'hFF000000;

   localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd1024;
   localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd768;
   localparam logic [14:0] ROW_STRIDE_RST    = 15'd1024;
   localparam logic [11:0] TOP_CLIP_RST      = 12'd0;

   typedef enum logic [2:0] {
      CSR_SCREEN_WIDTH  = 3'd0,
      CSR_SCREEN_HEIGHT = 3'd1,
      CSR_ROW_STRIDE    = 3'd2,
      CSR_TOP_CLIP_ROW  = 3'd3,
      CSR_PIXEL_FORMAT  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      FMT_GRAY8  = 2'd0,
      FMT_RGB565 = 2'd1,
      FMT_ARGB32 = 2'd2
   } fmt_type;

   typedef enum logic [1:0] {
      FUNC_FILL = 2'd0,
      FUNC_RING = 2'd1,
      FUNC_ARC  = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef struct packed {
      logic [12:0] width;
      logic [12:0] height;
      logic [14:0] stride;
      logic [11:0] top;
      logic [1:0]  fmt;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [13:0] cx;
      logic signed [13:0] cy;
      logic signed [12:0] dy;
      logic [7:0]         gray;
      logic               right;
      logic               down;
      logic               ring_two;
      logic               kill;
   } side_type;

   typedef struct packed {
      logic        ok;
      logic [12:0] x;
      logic [12:0] y;
      logic [12:0] w;
   } span_type;

   typedef struct packed {
      span_type   s0;
      span_type   s1;
      logic [7:0] gray;
   } entry_type;

endpackage

[design/circle_arc_span_rasterizer_core.sv]
// Scanline circle span rasterizer. Each request beat describes one row of a
// filled circle, a ring or a corner arc and yields zero to two clipped spans,
// each with byte address, row, column, length, packed pixel and a last flag.
// A request is taken every cycle while req_stall is low and passes the stages
// (input, radius/offset, squaring, radicand, twelve square-root steps,
// geometry, clip) to the span queue, then the back-end selection and output
// registers. The back end delivers one span per cycle while rsp_stall is low.
// req_stall rises when a span waits at the full four-entry span queue.
module circle_arc_span_rasterizer_core
   import carsr_pkg::*;
#(
   parameter int SPAN_QUEUE_DEPTH = QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic signed [13:0] req_centre_x,
   input  logic signed [13:0] req_centre_y,
   input  logic [11:0]        req_radius,
   input  logic [11:0]        req_ring_thickness,
   input  logic signed [12:0] req_row_offset,
   input  logic [7:0]         req_gray_level,
   input  logic               req_quad_right,
   input  logic               req_quad_down,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [25:0]        rsp_span_address,
   output logic [11:0]        rsp_span_row,
   output logic [11:0]        rsp_span_column,
   output logic [12:0]        rsp_span_length,
   output logic [31:0]        rsp_pixel_word,
   output logic               rsp_last_span
);

   cfg_type   cfg_ff;
   logic      push, pop, q_empty, q_full;
   entry_type push_entry, head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= SCREEN_WIDTH_RST;
         cfg_ff.height <= SCREEN_HEIGHT_RST;
         cfg_ff.stride <= ROW_STRIDE_RST;
         cfg_ff.top    <= TOP_CLIP_RST;
         cfg_ff.fmt    <= FMT_GRAY8;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  cfg_ff.width  <= csr_wdata[12:0];
            CSR_SCREEN_HEIGHT: cfg_ff.height <= csr_wdata[12:0];
            CSR_ROW_STRIDE:    cfg_ff.stride <= csr_wdata[14:0];
            CSR_TOP_CLIP_ROW:  cfg_ff.top    <= csr_wdata[11:0];
            CSR_PIXEL_FORMAT:  cfg_ff.fmt    <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   carsr_front u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_centre_x       (req_centre_x),
      .req_centre_y       (req_centre_y),
      .req_radius         (req_radius),
      .req_ring_thickness (req_ring_thickness),
      .req_row_offset     (req_row_offset),
      .req_gray_level     (req_gray_level),
      .req_quad_right     (req_quad_right),
      .req_quad_down      (req_quad_down),
      .q_full             (q_full),
      .push               (push),
      .push_entry         (push_entry)
   );

   carsr_queue #(
      .DEPTH (SPAN_QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (q_empty),
      .full       (q_full)
   );

   carsr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_empty          (q_empty),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_span_address (rsp_span_address),
      .rsp_span_row     (rsp_span_row),
      .rsp_span_column  (rsp_span_column),
      .rsp_span_length  (rsp_span_length),
      .rsp_pixel_word   (rsp_pixel_word),
      .rsp_last_span    (rsp_last_span)
   );

endmodule

[design/carsr_isqrt.sv]
module carsr_isqrt
   import carsr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [NUM_BITS-1:0]  in_n_o,
   input  logic [NUM_BITS-1:0]  in_n_i,
   input  side_type             in_side,
   output logic                 out_valid,
   output logic [ROOT_BITS-1:0] out_root_o,
   output logic [ROOT_BITS-1:0] out_root_i,
   output side_type             out_side
);

   logic                 valid_ff  [ROOT_BITS];
   logic [REM_BITS-1:0]  rem_o_ff  [ROOT_BITS];
   logic [REM_BITS-1:0]  rem_i_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_o_ff [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_i_ff [ROOT_BITS];
   side_type             side_ff   [ROOT_BITS];

   // one result bit per stage, most significant first
   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
      localparam int B = ROOT_BITS - 1 - k;
      logic                 valid_prev;
      logic [REM_BITS-1:0]  rem_o_prev, rem_i_prev, delta_o, delta_i;
      logic [REM_BITS-1:0]  rem_o_in, rem_i_in;
      logic [ROOT_BITS-1:0] root_o_prev, root_i_prev, root_o_in, root_i_in;
      side_type             side_prev;

      if (k == 0) begin : g_first
         assign valid_prev  = in_valid;
         assign rem_o_prev  = REM_BITS'(in_n_o);
         assign rem_i_prev  = REM_BITS'(in_n_i);
         assign root_o_prev = '0;
         assign root_i_prev = '0;
         assign side_prev   = in_side;
      end else begin : g_next
         assign valid_prev  = valid_ff[k-1];
         assign rem_o_prev  = rem_o_ff[k-1];
         assign rem_i_prev  = rem_i_ff[k-1];
         assign root_o_prev = root_o_ff[k-1];
         assign root_i_prev = root_i_ff[k-1];
         assign side_prev   = side_ff[k-1];
      end

      always_comb begin
         delta_o = (REM_BITS'(root_o_prev) << (B + 1)) + (REM_BITS'(1) << (2 * B));
         delta_i = (REM_BITS'(root_i_prev) << (B + 1)) + (REM_BITS'(1) << (2 * B));
         rem_o_in  = rem_o_prev;
         root_o_in = root_o_prev;
         rem_i_in  = rem_i_prev;
         root_i_in = root_i_prev;
         if (rem_o_prev >= delta_o) begin
            rem_o_in  = rem_o_prev - delta_o;
            root_o_in = root_o_prev | (ROOT_BITS'(1) << B);
         end
         if (rem_i_prev >= delta_i) begin
            rem_i_in  = rem_i_prev - delta_i;
            root_i_in = root_i_prev | (ROOT_BITS'(1) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
         if (en) begin
            rem_o_ff[k]  <= rem_o_in;
            rem_i_ff[k]  <= rem_i_in;
            root_o_ff[k] <= root_o_in;
            root_i_ff[k] <= root_i_in;
            side_ff[k]   <= side_prev;
         end
      end
   end

   assign out_valid  = valid_ff[ROOT_BITS-1];
   assign out_root_o = root_o_ff[ROOT_BITS-1];
   assign out_root_i = root_i_ff[ROOT_BITS-1];
   assign out_side   = side_ff[ROOT_BITS-1];

endmodule

[design/carsr_front.sv]
module carsr_front
   import carsr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic signed [13:0] req_centre_x,
   input  logic signed [13:0] req_centre_y,
   input  logic [11:0]        req_radius,
   input  logic [11:0]        req_ring_thickness,
   input  logic signed [12:0] req_row_offset,
   input  logic [7:0]         req_gray_level,
   input  logic               req_quad_right,
   input  logic               req_quad_down,
   input  logic               q_full,
   output logic               push,
   output entry_type          push_entry
);

   function automatic span_type clip(input logic signed [16:0] x,
                                     input logic signed [16:0] y,
                                     input logic signed [16:0] w,
                                     input logic v, input cfg_type c);
      logic signed [16:0] xx, ww, sw;
      span_type s;
      sw = signed'({4'b0, c.width});
      xx = x;
      ww = w;
      if (xx < 0) begin
         ww = ww + xx;
         xx = '0;
      end
      s.ok = v && (y >= 0) && (y >= signed'({5'b0, c.top})) && (ww > 0) && (xx < sw)
             && (y < signed'({4'b0, c.height}));
      if (xx + ww > sw) begin
         ww = sw - xx;
      end
      s.x = xx[12:0];
      s.y = y[12:0];
      s.w = ww[12:0];
      return s;
   endfunction

   logic fen;

   // stage 0: input beat
   logic        s0_valid_ff;
   logic [11:0] s0_r_ff, s0_th_ff;
   side_type    s0_side_ff;

   // stage 1: inner radius, offset magnitude, classification
   logic        s1_valid_ff;
   logic [11:0] s1_r_ff, s1_ri_ff;
   logic [12:0] s1_ady_ff;
   side_type    s1_side_ff;
   logic [12:0] s1_ady_in;
   logic [11:0] s1_ri_in;
   logic [12:0] s1_diff;
   side_type    s1_side_in;

   // stage 2: squares
   logic                s2_valid_ff;
   logic [NUM_BITS-1:0] s2_rr_ff, s2_riri_ff;
   logic [NUM_BITS:0]   s2_aa_ff;
   logic                s2_inner_ff;
   side_type            s2_side_ff;

   // stage 3: radicands
   logic                s3_valid_ff;
   logic [NUM_BITS-1:0] s3_n_o_ff, s3_n_i_ff;
   side_type            s3_side_ff;

   logic                 r_valid;
   logic [ROOT_BITS-1:0] hwo, hwi;
   side_type             r_side;

   // geometry stage
   logic               g_valid_ff, g_v0_ff, g_v1_ff;
   logic signed [16:0] g_x0_ff, g_x1_ff, g_y_ff, g_w0_ff, g_w1_ff;
   logic [7:0]         g_gray_ff;
   logic               g_v0_in, g_v1_in;
   logic signed [16:0] g_x0_in, g_x1_in, g_y_in, g_w0_in, g_w1_in;
   logic signed [16:0] cx_w, cy_w, dy_w, hwo_w, hwi_w, seg_w;

   // clip stage
   logic      c_valid_ff;
   entry_type c_entry_ff;
   entry_type c_entry_in;
   logic      c_has;

   assign c_has     = c_entry_ff.s0.ok || c_entry_ff.s1.ok;
   assign fen       = !(c_valid_ff && c_has && q_full);
   assign req_stall = !fen;
   assign push      = c_valid_ff && c_has && fen;
   assign push_entry = c_entry_ff;

   always_comb begin
      s1_diff = 13'({1'b0, s0_r_ff}) - 13'({1'b0, s0_th_ff});
      s1_ri_in = (s0_th_ff > s0_r_ff) ? 12'd0 : s1_diff[11:0];
      s1_ady_in = s0_side_ff.dy[12] ? 13'(-s0_side_ff.dy) : 13'(s0_side_ff.dy);
      s1_side_in = s0_side_ff;
      s1_side_in.ring_two = (s1_ri_in != 12'd0) && (s1_ady_in <= 13'({1'b0, s1_ri_in}));
      s1_side_in.kill = (s1_ady_in > 13'({1'b0, s0_r_ff})) || (s0_side_ff.func == FUNC_NONE)
                        || ((s0_side_ff.func == FUNC_ARC) && s0_side_ff.dy[12]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         g_valid_ff  <= 1'b0;
         c_valid_ff  <= 1'b0;
      end else if (fen) begin
         s0_valid_ff <= req_valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         g_valid_ff  <= r_valid;
         c_valid_ff  <= g_valid_ff;
      end
      if (fen) begin
         s0_r_ff             <= req_radius;
         s0_th_ff            <= req_ring_thickness;
         s0_side_ff.func     <= req_func;
         s0_side_ff.cx       <= req_centre_x;
         s0_side_ff.cy       <= req_centre_y;
         s0_side_ff.dy       <= req_row_offset;
         s0_side_ff.gray     <= req_gray_level;
         s0_side_ff.right    <= req_quad_right;
         s0_side_ff.down     <= req_quad_down;
         s0_side_ff.ring_two <= 1'b0;
         s0_side_ff.kill     <= 1'b0;

         s1_r_ff    <= s0_r_ff;
         s1_ri_ff   <= s1_ri_in;
         s1_ady_ff  <= s1_ady_in;
         s1_side_ff <= s1_side_in;

         s2_rr_ff    <= s1_r_ff * s1_r_ff;
         s2_riri_ff  <= s1_ri_ff * s1_ri_ff;
         s2_aa_ff    <= s1_ady_ff * s1_ady_ff;
         s2_inner_ff <= s1_ady_ff <= 13'({1'b0, s1_ri_ff});
         s2_side_ff  <= s1_side_ff;

         s3_n_o_ff  <= s2_side_ff.kill ? '0
                       : NUM_BITS'(25'({1'b0, s2_rr_ff}) - s2_aa_ff);
         s3_n_i_ff  <= (s2_side_ff.kill || !s2_inner_ff) ? '0
                       : NUM_BITS'(25'({1'b0, s2_riri_ff}) - s2_aa_ff);
         s3_side_ff <= s2_side_ff;
      end
   end

   carsr_isqrt u_isqrt (
      .clock      (clock),
      .reset      (reset),
      .en         (fen),
      .in_valid   (s3_valid_ff),
      .in_n_o     (s3_n_o_ff),
      .in_n_i     (s3_n_i_ff),
      .in_side    (s3_side_ff),
      .out_valid  (r_valid),
      .out_root_o (hwo),
      .out_root_i (hwi),
      .out_side   (r_side)
   );

   always_comb begin
      cx_w  = 17'(r_side.cx);
      cy_w  = 17'(r_side.cy);
      dy_w  = 17'(r_side.dy);
      hwo_w = signed'({5'b0, hwo});
      hwi_w = signed'({5'b0, hwi});
      seg_w = hwo_w - hwi_w;
      g_v0_in = 1'b0;
      g_v1_in = 1'b0;
      g_x0_in = cx_w - hwo_w;
      g_x1_in = cx_w + hwi_w + 17'sd1;
      g_y_in  = cy_w + dy_w;
      g_w0_in = (hwo_w <<< 1) + 17'sd1;
      g_w1_in = seg_w;
      if (!r_side.kill) begin
         unique case (r_side.func)
            FUNC_FILL: begin
               g_v0_in = 1'b1;
            end
            FUNC_RING: begin
               if (r_side.ring_two) begin
                  if (seg_w > 0) begin
                     g_v0_in = 1'b1;
                     g_v1_in = 1'b1;
                     g_w0_in = seg_w;
                  end
               end else begin
                  g_v0_in = 1'b1;
               end
            end
            FUNC_ARC: begin
               if (seg_w > 0) begin
                  g_v0_in = 1'b1;
                  g_w0_in = seg_w;
                  if (r_side.right) begin
                     g_x0_in = cx_w + hwi_w;
                  end
                  if (!r_side.down) begin
                     g_y_in = cy_w - dy_w;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      c_entry_in.s0   = clip(g_x0_ff, g_y_ff, g_w0_ff, g_v0_ff, cfg);
      c_entry_in.s1   = clip(g_x1_ff, g_y_ff, g_w1_ff, g_v1_ff, cfg);
      c_entry_in.gray = g_gray_ff;
   end

   always_ff @(posedge clock) begin
      if (fen) begin
         g_v0_ff    <= g_v0_in;
         g_v1_ff    <= g_v1_in;
         g_x0_ff    <= g_x0_in;
         g_x1_ff    <= g_x1_in;
         g_y_ff     <= g_y_in;
         g_w0_ff    <= g_w0_in;
         g_w1_ff    <= g_w1_in;
         g_gray_ff  <= r_side.gray;
         c_entry_ff <= c_entry_in;
      end
   end

endmodule

[design/carsr_queue.sv]
module carsr_queue
   import carsr_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      empty,
   output logic      full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   entry_type     mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [PW:0]   count_ff;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (PW+1)'(DEPTH));
   assign head  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         count_ff <= count_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

[design/carsr_back.sv]
module carsr_back
   import carsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_empty,
   input  entry_type   head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [25:0] rsp_span_address,
   output logic [11:0] rsp_span_row,
   output logic [11:0] rsp_span_column,
   output logic [12:0] rsp_span_length,
   output logic [31:0] rsp_pixel_word,
   output logic        rsp_last_span
);

   logic        sel_ff;
   logic        b_valid_ff, b_last_ff;
   logic [12:0] b_x_ff, b_y_ff, b_w_ff;
   logic [31:0] b_pix_ff;

   logic        out_adv, b_adv, take, use_s0, cur_last;
   span_type    cur;
   logic [31:0] pix_in;
   logic [27:0] row_bytes;
   logic [15:0] col_bytes;

   logic        rsp_valid_ff, rsp_last_ff;
   logic [25:0] rsp_addr_ff;
   logic [11:0] rsp_row_ff, rsp_col_ff;
   logic [12:0] rsp_len_ff;
   logic [31:0] rsp_pix_ff;

   assign out_adv  = !rsp_valid_ff || !rsp_stall;
   assign b_adv    = !b_valid_ff || out_adv;
   assign take     = b_adv && !q_empty;
   assign use_s0   = !sel_ff && head.s0.ok;
   assign cur      = use_s0 ? head.s0 : head.s1;
   assign cur_last = use_s0 ? !head.s1.ok : 1'b1;
   assign pop      = take && cur_last;

   always_comb begin
      unique case (cfg.fmt)
         FMT_RGB565: pix_in = 32'({head.gray[7:3], head.gray[7:2], head.gray[7:3]});
         FMT_ARGB32: pix_in = ARGB_ALPHA | 32'({head.gray, head.gray, head.gray});
         default:    pix_in = 32'(head.gray);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff     <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (b_adv) begin
         b_valid_ff <= !q_empty;
         if (!q_empty) begin
            sel_ff <= !cur_last;
         end
      end
      if (take) begin
         b_x_ff    <= cur.x;
         b_y_ff    <= cur.y;
         b_w_ff    <= cur.w;
         b_last_ff <= cur_last;
         b_pix_ff  <= pix_in;
      end
   end

   always_comb begin
      row_bytes = b_y_ff * cfg.stride;
      unique case (cfg.fmt)
         FMT_RGB565: col_bytes = 16'(b_x_ff) << 1;
         FMT_ARGB32: col_bytes = 16'(b_x_ff) << 2;
         default:    col_bytes = 16'(b_x_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= b_valid_ff;
      end
      if (out_adv && b_valid_ff) begin
         rsp_addr_ff <= 26'(row_bytes + 28'(col_bytes));
         rsp_row_ff  <= b_y_ff[11:0] & COORD_MASK;
         rsp_col_ff  <= b_x_ff[11:0] & COORD_MASK;
         rsp_len_ff  <= b_w_ff;
         rsp_pix_ff  <= b_pix_ff;
         rsp_last_ff <= b_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_span_address = rsp_addr_ff;
   assign rsp_span_row     = rsp_row_ff;
   assign rsp_span_column  = rsp_col_ff;
   assign rsp_span_length  = rsp_len_ff;
   assign rsp_pixel_word   = rsp_pix_ff;
   assign rsp_last_span    = rsp_last_ff;

endmodule

[design/carsr_checker.sv]
module carsr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [25:0] rsp_span_address,
   input logic [12:0] rsp_span_length,
   input logic        csr_ready
);

   // no span is ever empty after clipping
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_span_length != 13'd0))
      else $error("empty span delivered");

   // output stage is cleared by reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("span valid right after reset");

   // a stalled beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_span_address))
      else $error("stalled span changed");

   // register writes never back-pressure
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr port not ready");

endmodule

bind circle_arc_span_rasterizer_core carsr_checker u_checker (.*);

[dv/circle_arc_span_rasterizer_core_tb.sv]
`timescale 1ns / 1ps

module circle_arc_span_rasterizer_core_tb;
   import carsr_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [1:0] FMT_SPARE   = 2'd3;
   localparam int         DRAIN_CYCLES = 60;

   typedef struct {
      logic [1:0]         func;
      logic signed [13:0] cx;
      logic signed [13:0] cy;
      logic [11:0]        radius;
      logic [11:0]        thick;
      logic signed [12:0] dy;
      logic [7:0]         gray;
      logic               right;
      logic               down;
   } row_req_type;

   typedef struct {
      logic [25:0] addr;
      logic [11:0] row;
      logic [11:0] col;
      logic [12:0] len;
      logic [31:0] pix;
      logic        last;
   } exp_span_type;

   // directed row: spans_known < 0 means the predictor alone decides
   typedef struct {
      row_req_type req;
      int          spans_known;
      logic [25:0] addr;
      logic [12:0] len;
   } dir_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func = '0;
   logic signed [13:0] req_centre_x = '0;
   logic signed [13:0] req_centre_y = '0;
   logic [11:0]        req_radius = '0;
   logic [11:0]        req_ring_thickness = '0;
   logic signed [12:0] req_row_offset = '0;
   logic [7:0]         req_gray_level = '0;
   logic               req_quad_right = 1'b0;
   logic               req_quad_down = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b1;
   logic [25:0]        rsp_span_address;
   logic [11:0]        rsp_span_row;
   logic [11:0]        rsp_span_column;
   logic [12:0]        rsp_span_length;
   logic [31:0]        rsp_pixel_word;
   logic               rsp_last_span;

   int unsigned  cfg_width, cfg_height, cfg_stride, cfg_top, cfg_fmt;
   exp_span_type pending_spans[$];
   exp_span_type row_spans[$];
   int           mismatches = 0;
   int           stall_left = 0;
   bit           quiet_rsp = 0;

   circle_arc_span_rasterizer_core i_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("circle_arc_span_rasterizer_core_tb failed");
      $finish;
   end

   function automatic int unsigned int_sqrt(int unsigned n);
      int unsigned res, bit_v;
      res = 0;
      bit_v = 32'h4000_0000;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n -= res + bit_v;
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] pack_pixel(logic [7:0] g);
      logic [31:0] gw;
      gw = 32'(g);
      case (cfg_fmt)
         FMT_RGB565: return ((gw >> 3) << 11) | ((gw >> 2) << 5) | (gw >> 3);
         FMT_ARGB32: return ARGB_ALPHA | (gw << 16) | (gw << 8) | gw;
         default:    return gw;
      endcase
   endfunction

   // clip one span to the screen and the protected rows, keep what survives
   function automatic void clip_span(int x, int y, int w, logic [7:0] g);
      exp_span_type s;
      longint       pb;
      pb = (cfg_fmt == FMT_RGB565) ? 2 : (cfg_fmt == FMT_ARGB32) ? 4 : 1;
      if (x < 0) begin
         w += x;
         x = 0;
      end
      if (y < 0 || y < int'(cfg_top)) return;
      if (w <= 0 || x >= int'(cfg_width) || y >= int'(cfg_height)) return;
      if (x + w > int'(cfg_width)) w = int'(cfg_width) - x;
      s.addr = 26'(longint'(y) * cfg_stride + longint'(x) * pb);
      s.row  = 12'(y);
      s.col  = 12'(x);
      s.len  = 13'(w);
      s.pix  = pack_pixel(g);
      s.last = 1'b0;
      row_spans.push_back(s);
   endfunction

   function automatic void rasterize_row(row_req_type q);
      int cx, cy, r, th, dy, ri, ady, hwo, hwi, seg;
      cx = q.cx;
      cy = q.cy;
      r  = q.radius;
      th = q.thick;
      dy = q.dy;
      ri = (r - th < 0) ? 0 : r - th;
      ady = dy < 0 ? -dy : dy;
      row_spans.delete();
      if (ady > r || q.func == FUNC_UNUSED) return;
      hwo = int_sqrt(r * r - ady * ady);
      if (q.func == FUNC_FILL) begin
         clip_span(cx - hwo, cy + dy, hwo * 2 + 1, q.gray);
      end else if (q.func == FUNC_RING) begin
         if (ri > 0 && ady <= ri) begin
            hwi = int_sqrt(ri * ri - ady * ady);
            seg = hwo - hwi;
            if (seg > 0) begin
               clip_span(cx - hwo, cy + dy, seg, q.gray);
               clip_span(cx + hwi + 1, cy + dy, seg, q.gray);
            end
         end else begin
            clip_span(cx - hwo, cy + dy, hwo * 2 + 1, q.gray);
         end
      end else begin
         if (dy < 0) return;
         hwi = (dy <= ri) ? int_sqrt(ri * ri - dy * dy) : 0;
         seg = hwo - hwi;
         if (seg > 0)
            clip_span(q.right ? cx + hwi : cx - hwo, q.down ? cy + dy : cy - dy,
                      seg, q.gray);
      end
      if (row_spans.size() > 0) row_spans[row_spans.size() - 1].last = 1'b1;
   endfunction

   function automatic row_req_type random_row();
      row_req_type q;
      int r, dy, row;
      q.func  = 2'($urandom_range(0, 2));
      q.gray  = 8'($urandom);
      q.right = 1'($urandom);
      q.down  = 1'($urandom);
      if ($urandom_range(0, 99) < 15) begin
         // noise: any bit pattern, including the unused function code
         q.func   = 2'($urandom);
         q.cx     = 14'($urandom);
         q.cy     = 14'($urandom);
         q.radius = 12'($urandom);
         q.thick  = 12'($urandom);
         q.dy     = 13'($urandom);
         return q;
      end
      case ($urandom_range(0, 19))
         0:       r = $urandom_range(0, 4095);
         1, 2, 3: r = $urandom_range(0, 1500);
         default: r = $urandom_range(0, 200);
      endcase
      q.radius = 12'(r);
      q.thick  = 12'($urandom_range(0, r + 5));
      if ($urandom_range(0, 9) == 0) dy = r + $urandom_range(1, 20);
      else dy = $urandom_range(0, r);
      if (dy > 4095) dy = 4095;
      if (q.func != FUNC_ARC || $urandom_range(0, 9) == 0)
         if ($urandom_range(0, 1)) dy = -dy;
      q.dy = 13'(dy);
      row  = int'(cfg_top) - 10 + $urandom_range(0, cfg_height - cfg_top + 20);
      q.cy = 14'((q.func == FUNC_ARC && !q.down) ? row + dy : row - dy);
      q.cx = 14'(int'($urandom_range(0, cfg_width + 2 * r + 40)) - r - 20);
      return q;
   endfunction

   function automatic dir_row_type mk(logic [1:0] f, int cx, int cy, int r, int th,
                                      int dy, int g, bit rt, bit dn, int known,
                                      int addr, int len);
      dir_row_type d;
      d.req = '{f, 14'(cx), 14'(cy), 12'(r), 12'(th), 13'(dy), 8'(g), rt, dn};
      d.spans_known = known;
      d.addr = 26'(addr);
      d.len  = 13'(len);
      return d;
   endfunction

   task automatic csr_write(csr_index_type idx, int unsigned data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = 16'(data);
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SCREEN_WIDTH:  cfg_width  = data & 32'h1FFF;
         CSR_SCREEN_HEIGHT: cfg_height = data & 32'h1FFF;
         CSR_ROW_STRIDE:    cfg_stride = data & 32'h7FFF;
         CSR_TOP_CLIP_ROW:  cfg_top    = data & 32'hFFF;
         CSR_PIXEL_FORMAT:  cfg_fmt    = data & 32'h3;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_spans.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // present one row; leave valid high so a back-to-back beat needs no drop
   task automatic send_row(row_req_type q, int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid          = 1'b1;
      req_func           = q.func;
      req_centre_x       = q.cx;
      req_centre_y       = q.cy;
      req_radius         = q.radius;
      req_ring_thickness = q.thick;
      req_row_offset     = q.dy;
      req_gray_level     = q.gray;
      req_quad_right     = q.right;
      req_quad_down      = q.down;
      do @(posedge clock); while (req_stall);
      rasterize_row(q);
      foreach (row_spans[i]) pending_spans.push_back(row_spans[i]);
   endtask

   task automatic park_sender();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      exp_span_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         stall_left = quiet_rsp ? 0 : $urandom_range(0, 7);
         if (pending_spans.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected span beat: addr %0h row %0d col %0d",
                        rsp_span_address, rsp_span_row, rsp_span_column);
         end else begin
            e = pending_spans.pop_front();
            if (rsp_span_address !== e.addr || rsp_span_row !== e.row ||
                rsp_span_column !== e.col || rsp_span_length !== e.len ||
                rsp_pixel_word !== e.pix || rsp_last_span !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"span mismatch: exp addr %0h row %0d col %0d len %0d",
                            " pix %0h last %0b, got addr %0h row %0d col %0d",
                            " len %0d pix %0h last %0b"},
                           e.addr, e.row, e.col, e.len, e.pix, e.last,
                           rsp_span_address, rsp_span_row, rsp_span_column,
                           rsp_span_length, rsp_pixel_word, rsp_last_span);
            end
         end
      end
   end

   initial begin
      dir_row_type dir_rows[$];
      int unsigned phase_cfg[5][5];
      bit          quiet_req;
      int          gap;
      cfg_width  = SCREEN_WIDTH_RST;
      cfg_height = SCREEN_HEIGHT_RST;
      cfg_stride = ROW_STRIDE_RST;
      cfg_top    = TOP_CLIP_RST;
      cfg_fmt    = FMT_GRAY8;
      quiet_req  = 0;
      phase_cfg = '{'{4096, 4096, 16384, 0, FMT_ARGB32},
                    '{1, 1, 1, 0, FMT_RGB565},
                    '{640, 4096, 1280, 4095, FMT_SPARE},
                    '{800, 600, 3200, 50, FMT_ARGB32},
                    '{1024, 768, 1024, 0, FMT_GRAY8}};

      dir_rows.push_back(mk(FUNC_FILL, 100, 100, 0, 0, 0, 255, 0, 0, 1, 102500, 1));
      dir_rows.push_back(mk(FUNC_FILL, 100, 100, 10, 0, 11, 1, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(FUNC_FILL, 100, 100, 10, 0, -11, 1, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(FUNC_UNUSED, 100, 100, 10, 0, 0, 7, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(FUNC_ARC, 100, 100, 10, 3, -3, 9, 1, 1, 0, 0, 0));
      dir_rows.push_back(mk(FUNC_FILL, 0, 0, 4095, 0, 0, 0, 0, 0, 1, 0, 1024));
      dir_rows.push_back(mk(FUNC_FILL, 50, -5, 3, 0, 0, 8, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(FUNC_FILL, 50, 768, 3, 0, 0, 8, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(FUNC_FILL, 1024, 10, 0, 0, 0, 8, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(FUNC_RING, 200, 50, 10, 0, 0, 8, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(FUNC_RING, 50, 20, 10, 20, 0, 3, 0, 0, 1, 20520, 21));
      dir_rows.push_back(mk(FUNC_RING, 200, 50, 10, 3, 0, 33, 0, 0, -1, 0, 0));
      dir_rows.push_back(mk(FUNC_RING, 200, 50, 10, 3, -9, 33, 0, 0, -1, 0, 0));
      dir_rows.push_back(mk(FUNC_RING, 5, 50, 40, 4, 2, 66, 0, 0, -1, 0, 0));
      dir_rows.push_back(mk(FUNC_ARC, 300, 300, 50, 10, 20, 90, 1, 1, -1, 0, 0));
      dir_rows.push_back(mk(FUNC_ARC, 300, 300, 50, 10, 20, 90, 0, 0, -1, 0, 0));
      dir_rows.push_back(mk(FUNC_ARC, 300, 300, 50, 10, 45, 90, 1, 0, -1, 0, 0));
      dir_rows.push_back(mk(FUNC_ARC, 300, 300, 5, 5, 0, 90, 1, 1, -1, 0, 0));
      dir_rows.push_back(mk(FUNC_FILL, -8192, -8192, 4095, 0, 4095, 255, 1, 1, 0, 0, 0));
      dir_rows.push_back(mk(FUNC_FILL, 8191, 8191, 4095, 4095, -4096, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(FUNC_FILL, 1000, 767, 30, 0, 0, 128, 0, 0, -1, 0, 0));
      dir_rows.push_back(mk(FUNC_RING, 1020, 400, 4095, 4095, 100, 200, 1, 1, -1, 0, 0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         rasterize_row(dir_rows[i].req);
         if (dir_rows[i].spans_known >= 0 &&
             (row_spans.size() != dir_rows[i].spans_known ||
              (row_spans.size() == 1 && (row_spans[0].addr !== dir_rows[i].addr ||
                                         row_spans[0].len !== dir_rows[i].len)))) begin
            mismatches++;
            if (mismatches <= 10)
               $display("directed row %0d: span count or placement off (%0d spans)",
                        i, row_spans.size());
         end
         send_row(dir_rows[i].req, $urandom_range(0, 7));
      end
      park_sender();
      wait_idle();

      for (int p = 0; p < 5; p++) begin
         csr_write(CSR_SCREEN_WIDTH, phase_cfg[p][0]);
         csr_write(CSR_SCREEN_HEIGHT, phase_cfg[p][1]);
         csr_write(CSR_ROW_STRIDE, phase_cfg[p][2]);
         csr_write(CSR_TOP_CLIP_ROW, phase_cfg[p][3]);
         csr_write(CSR_PIXEL_FORMAT, phase_cfg[p][4]);
         for (int n = 0; n < 400; n++) begin
            if (n % 64 == 0) begin
               quiet_req = ($urandom_range(0, 3) == 0);
               quiet_rsp = ($urandom_range(0, 3) == 0);
            end
            if (p == 2 && n == 200) begin
               // hold until the span queue runs dry
               park_sender();
               while (pending_spans.size() != 0) @(posedge clock);
            end
            gap = quiet_req ? 0 : $urandom_range(0, 7);
            send_row(random_row(), gap);
         end
         park_sender();
         wait_idle();
      end

      if (mismatches == 0 && pending_spans.size() == 0) begin
         $display("circle_arc_span_rasterizer_core_tb passed");
      end else begin
         $display("circle_arc_span_rasterizer_core_tb failed");
      end
      $finish;
   end

endmodule

[circle_arc_span_rasterizer_core.f]
design/carsr_pkg.sv
design/carsr_isqrt.sv
design/carsr_front.sv
design/carsr_queue.sv
design/carsr_back.sv
design/circle_arc_span_rasterizer_core.sv
design/carsr_checker.sv
dv/circle_arc_span_rasterizer_core_tb.sv
